@@ hdl/interrupt_latch_mask_dispatcher_defines.svh @@
// Assertion macros shared by the interrupt dispatcher checker.
`ifndef INTERRUPT_LATCH_MASK_DISPATCHER_DEFINES_SVH
`define INTERRUPT_LATCH_MASK_DISPATCHER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define ILMD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define ILMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ilmd_pkg.sv @@
// Package with the constants, types and codes of the interrupt dispatcher.
package ilmd_pkg;

    // Geometry of the two banks.
    localparam int BANK_WIDTH  = 24;
    localparam int EVENT_COUNT = 48;

    // Fixed field widths of the channels.
    localparam int MODE_W  = 3;
    localparam int EV_W    = 6;
    localparam int WORD_W  = 24;
    localparam int KIND_W  = 3;

    // Bit position inside a bank and walk position over both banks.
    localparam int BIT_W = (BANK_WIDTH > 1) ? $clog2(BANK_WIDTH) : 1;
    localparam int IDX_W = $clog2(2 * BANK_WIDTH);

    typedef logic [WORD_W-1:0]        word_t;
    typedef logic [BANK_WIDTH-1:0]    bank_t;
    typedef logic [1:0][BANK_WIDTH-1:0] bank_pair_t;
    typedef logic [2*BANK_WIDTH-1:0]  pend_t;
    typedef logic [BIT_W-1:0]         bit_pos_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [EV_W:0]            ev_ext_t;

    localparam ev_ext_t BW_EXT = ev_ext_t'(BANK_WIDTH);
    localparam ev_ext_t EC_EXT = ev_ext_t'(EVENT_COUNT);

    // Bits of a bank whose events exist.
    function automatic bank_t bank_valid(input int first);
        bank_t v;
        for (int i = 0; i < BANK_WIDTH; i++) begin
            v[i] = ((first + i) < EVENT_COUNT);
        end
        return v;
    endfunction

    localparam bank_pair_t BANK_VALID = {bank_valid(BANK_WIDTH), bank_valid(0)};

    typedef enum logic [MODE_W-1:0] {
        MODE_COND    = 3'd0,
        MODE_SERVICE = 3'd1,
        MODE_MASK    = 3'd2,
        MODE_UNMASK  = 3'd3,
        MODE_CLEAR   = 3'd4,
        MODE_SENSE   = 3'd5
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DISPATCH = 3'd0,
        KIND_NONE     = 3'd1,
        KIND_DONE     = 3'd2,
        KIND_SENSE    = 3'd3,
        KIND_INVALID  = 3'd4
    } kind_t;

    // Updates that the sequencer asks of the state registers.
    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_COND,
        UPD_SERVICE,
        UPD_MASK,
        UPD_UNMASK,
        UPD_CLEAR
    } upd_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REPLY,
        ST_SCAN
    } state_t;

    typedef struct packed {
        upd_op_t    op;
        logic       bank;
        bit_pos_t   bit_pos;
        bank_pair_t occurred;
        bank_pair_t level;
    } upd_t;

    typedef struct packed {
        logic       irq;
        bank_t      wake;
        bank_pair_t sense;
        pend_t      pending;
    } stat_t;

endpackage

@@ hdl/ilmd_ifs.sv @@
// Channel interfaces of the interrupt dispatcher: command, result and configuration.
interface ilmd_cmd_if;
    logic                     valid;
    logic                     ready;
    logic [ilmd_pkg::MODE_W-1:0] mode;
    logic [ilmd_pkg::EV_W-1:0]   event_number;
    ilmd_pkg::word_t          occurred_low;
    ilmd_pkg::word_t          occurred_high;
    ilmd_pkg::word_t          level_low;
    ilmd_pkg::word_t          level_high;

    modport source (output valid, mode, event_number, occurred_low, occurred_high,
                    level_low, level_high, input ready);
    modport sink (input valid, mode, event_number, occurred_low, occurred_high,
                  level_low, level_high, output ready);
endinterface

interface ilmd_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ilmd_pkg::KIND_W-1:0] kind;
    logic [ilmd_pkg::EV_W-1:0]   dispatched_event;
    logic                        sense_bit;
    logic                        irq_line;
    ilmd_pkg::word_t             wake_flags;
    logic                        last;

    modport source (output valid, kind, dispatched_event, sense_bit, irq_line,
                    wake_flags, last, input ready);
    modport sink (input valid, kind, dispatched_event, sense_bit, irq_line,
                  wake_flags, last, output ready);
endinterface

interface ilmd_cfg_if;
    logic            valid;
    logic            ready;
    ilmd_pkg::word_t wake_select;

    modport source (output valid, wake_select, input ready);
    modport sink (input valid, wake_select, output ready);
endinterface

@@ hdl/ilmd_state.sv @@
// Status, mask, sense and wake registers of both banks with their update logic.
module ilmd_state (
    input  logic            clk,
    input  logic            rst_n,
    input  ilmd_pkg::upd_t  upd,
    input  logic            wake_sel_we,
    input  ilmd_pkg::word_t wake_sel_data,
    output ilmd_pkg::stat_t stat
);

    ilmd_pkg::bank_pair_t status_reg, status_next;
    ilmd_pkg::bank_pair_t mask_reg, mask_next;
    ilmd_pkg::bank_pair_t sense_reg, sense_next;
    ilmd_pkg::bank_t      wake_reg, wake_next;
    ilmd_pkg::bank_t      wake_sel_reg;
    ilmd_pkg::bank_pair_t en;
    ilmd_pkg::bank_t      onehot;

    // Pending events: status set, mask clear, event present.
    always_comb
    begin
        for (int b = 0; b < 2; b++) begin
            en[b] = status_reg[b] & ~mask_reg[b] & ilmd_pkg::BANK_VALID[b];
        end
    end

    assign onehot = ilmd_pkg::bank_t'(1) << upd.bit_pos;

    // Next state for the requested update.
    always_comb
    begin
        status_next = status_reg;
        mask_next   = mask_reg;
        sense_next  = sense_reg;
        wake_next   = wake_reg;
        unique case (upd.op)
            ilmd_pkg::UPD_COND:
            begin
                for (int b = 0; b < 2; b++) begin
                    status_next[b] = status_reg[b] |
                                     (upd.occurred[b] & ilmd_pkg::BANK_VALID[b]);
                    sense_next[b]  = upd.level[b] & ilmd_pkg::BANK_VALID[b];
                end
            end
            ilmd_pkg::UPD_SERVICE:
            begin
                for (int b = 0; b < 2; b++) begin
                    mask_next[b]   = mask_reg[b] |
                                     (status_reg[b] & ilmd_pkg::BANK_VALID[b]);
                    status_next[b] = status_reg[b] & ~en[b];
                end
                wake_next = wake_reg | (en[1] & wake_sel_reg & ilmd_pkg::BANK_VALID[1]);
            end
            ilmd_pkg::UPD_MASK:
            begin
                mask_next[upd.bank] = mask_reg[upd.bank] | onehot;
            end
            ilmd_pkg::UPD_UNMASK:
            begin
                mask_next[upd.bank] = mask_reg[upd.bank] & ~onehot;
            end
            ilmd_pkg::UPD_CLEAR:
            begin
                status_next[upd.bank] = status_reg[upd.bank] & ~onehot;
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    // State registers; every event starts masked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            status_reg   <= '0;
            mask_reg     <= '1;
            sense_reg    <= '0;
            wake_reg     <= '0;
            wake_sel_reg <= '0;
        end else begin
            status_reg <= status_next;
            mask_reg   <= mask_next;
            sense_reg  <= sense_next;
            wake_reg   <= wake_next;
            if (wake_sel_we) begin
                wake_sel_reg <= ilmd_pkg::bank_t'(wake_sel_data);
            end
        end
    end

    assign stat.irq     = |en;
    assign stat.wake    = wake_reg;
    assign stat.sense   = sense_reg;
    assign stat.pending = en;

endmodule

@@ hdl/interrupt_latch_mask_dispatcher.sv @@
// Top level of the two-bank interrupt latch, mask and dispatch block.
// Condition, mask, unmask, clear, sense and invalid items: accepted in the idle state,
// result registered from the reply state when space allows, before the next is taken.
// Service items: the bit walker steps one pending-word position a cycle unless held
// by a stalled output; one item per pending event, or a none item if nothing pends.
// Reset (rst_n, asynchronous) clears status, sense and wake bits and masks all events.
module interrupt_latch_mask_dispatcher (
    input logic         clk,
    input logic         rst_n,
    ilmd_cmd_if.sink    cmd,
    ilmd_rsp_if.source  rsp,
    ilmd_cfg_if.sink    cfg
);

    ilmd_pkg::state_t   state_reg, state_next;
    ilmd_pkg::kind_t    kind_reg, kind_next;
    logic               bank_reg, bank_next;
    ilmd_pkg::bit_pos_t bit_reg, bit_next;
    ilmd_pkg::pend_t    pend_reg, pend_next;
    ilmd_pkg::idx_t     idx_reg, idx_next;

    logic                       out_valid_reg, out_valid_next;
    ilmd_pkg::kind_t            out_kind_reg, out_kind_next;
    logic [ilmd_pkg::EV_W-1:0]  out_ev_reg, out_ev_next;
    logic                       out_sense_reg, out_sense_next;
    logic                       out_irq_reg, out_irq_next;
    ilmd_pkg::word_t            out_wake_reg, out_wake_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_load;
    logic                       space;

    ilmd_pkg::upd_t     upd;
    ilmd_pkg::stat_t    stat;
    ilmd_pkg::ev_ext_t  ev_ext;
    ilmd_pkg::ev_ext_t  bit_ext;
    logic               ev_bank;
    logic               ev_bad;
    ilmd_pkg::pend_t    pend_left;

    // Configuration is always taken.
    assign cfg.ready = 1'b1;

    ilmd_state u_state (
        .clk           (clk),
        .rst_n         (rst_n),
        .upd           (upd),
        .wake_sel_we   (cfg.valid),
        .wake_sel_data (cfg.wake_select),
        .stat          (stat)
    );

    // Event number split into bank and bit, with the range check.
    always_comb
    begin
        ev_ext  = {1'b0, cmd.event_number};
        ev_bank = (ev_ext >= ilmd_pkg::BW_EXT);
        bit_ext = ev_ext - (ev_bank ? ilmd_pkg::BW_EXT : '0);
        ev_bad  = (ev_ext >= ilmd_pkg::EC_EXT) || (bit_ext >= ilmd_pkg::BW_EXT);
    end

    assign space     = !out_valid_reg || rsp.ready;
    assign pend_left = pend_reg & ~(ilmd_pkg::pend_t'(1) << idx_reg);

    // Sequencer: decode, single reply, or walk of the pending word.
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        bank_next      = bank_reg;
        bit_next       = bit_reg;
        pend_next      = pend_reg;
        idx_next       = idx_reg;
        cmd.ready      = 1'b0;
        out_load       = 1'b0;
        out_kind_next  = out_kind_reg;
        out_ev_next    = out_ev_reg;
        out_sense_next = out_sense_reg;
        out_last_next  = out_last_reg;

        upd.op       = ilmd_pkg::UPD_NONE;
        upd.bank     = ev_bank;
        upd.bit_pos  = ilmd_pkg::bit_pos_t'(bit_ext);
        upd.occurred = {ilmd_pkg::bank_t'(cmd.occurred_high),
                        ilmd_pkg::bank_t'(cmd.occurred_low)};
        upd.level    = {ilmd_pkg::bank_t'(cmd.level_high),
                        ilmd_pkg::bank_t'(cmd.level_low)};

        unique case (state_reg)
            ilmd_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid) begin
                    bank_next  = ev_bank;
                    bit_next   = ilmd_pkg::bit_pos_t'(bit_ext);
                    state_next = ilmd_pkg::ST_REPLY;
                    unique case (ilmd_pkg::mode_t'(cmd.mode)) inside
                        ilmd_pkg::MODE_COND:
                        begin
                            upd.op    = ilmd_pkg::UPD_COND;
                            kind_next = ilmd_pkg::KIND_DONE;
                        end
                        ilmd_pkg::MODE_SERVICE:
                        begin
                            upd.op    = ilmd_pkg::UPD_SERVICE;
                            pend_next = stat.pending;
                            idx_next  = '0;
                            if (stat.pending == '0) begin
                                kind_next = ilmd_pkg::KIND_NONE;
                            end else begin
                                state_next = ilmd_pkg::ST_SCAN;
                            end
                        end
                        ilmd_pkg::MODE_MASK, ilmd_pkg::MODE_UNMASK,
                        ilmd_pkg::MODE_CLEAR, ilmd_pkg::MODE_SENSE:
                        begin
                            if (ev_bad) begin
                                kind_next = ilmd_pkg::KIND_INVALID;
                            end else if (cmd.mode == ilmd_pkg::MODE_SENSE) begin
                                kind_next = ilmd_pkg::KIND_SENSE;
                            end else begin
                                kind_next = ilmd_pkg::KIND_DONE;
                                if (cmd.mode == ilmd_pkg::MODE_MASK) begin
                                    upd.op = ilmd_pkg::UPD_MASK;
                                end else if (cmd.mode == ilmd_pkg::MODE_UNMASK) begin
                                    upd.op = ilmd_pkg::UPD_UNMASK;
                                end else begin
                                    upd.op = ilmd_pkg::UPD_CLEAR;
                                end
                            end
                        end
                        default:
                        begin
                            kind_next = ilmd_pkg::KIND_INVALID;
                        end
                    endcase
                end
            end
            ilmd_pkg::ST_REPLY:
            begin
                if (space) begin
                    out_load       = 1'b1;
                    out_kind_next  = kind_reg;
                    out_ev_next    = '0;
                    out_sense_next = (kind_reg == ilmd_pkg::KIND_SENSE) &&
                                     stat.sense[bank_reg][bit_reg];
                    out_last_next  = 1'b1;
                    state_next     = ilmd_pkg::ST_IDLE;
                end
            end
            ilmd_pkg::ST_SCAN:
            begin
                if (!pend_reg[idx_reg]) begin
                    idx_next = idx_reg + 1'b1;
                end else if (space) begin
                    out_load       = 1'b1;
                    out_kind_next  = ilmd_pkg::KIND_DISPATCH;
                    out_ev_next    = ilmd_pkg::EV_W'(idx_reg);
                    out_sense_next = 1'b0;
                    out_last_next  = (pend_left == '0);
                    pend_next      = pend_left;
                    idx_next       = idx_reg + 1'b1;
                    if (pend_left == '0) begin
                        state_next = ilmd_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ilmd_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register: irq and wake reflect the state after the item's update.
    assign out_valid_next = out_load || (out_valid_reg && !rsp.ready);
    assign out_irq_next   = out_load ? stat.irq : out_irq_reg;
    assign out_wake_next  = out_load ? ilmd_pkg::word_t'(stat.wake) : out_wake_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ilmd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        bank_reg      <= bank_next;
        bit_reg       <= bit_next;
        pend_reg      <= pend_next;
        idx_reg       <= idx_next;
        out_kind_reg  <= out_kind_next;
        out_ev_reg    <= out_ev_next;
        out_sense_reg <= out_sense_next;
        out_irq_reg   <= out_irq_next;
        out_wake_reg  <= out_wake_next;
        out_last_reg  <= out_last_next;
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.kind             = out_kind_reg;
    assign rsp.dispatched_event = out_ev_reg;
    assign rsp.sense_bit        = out_sense_reg;
    assign rsp.irq_line         = out_irq_reg;
    assign rsp.wake_flags       = out_wake_reg;
    assign rsp.last             = out_last_reg;

endmodule

@@ hdl/ilmd_checker.sv @@
// Port-level checker for the interrupt dispatcher and its bind to the top level.
`include "interrupt_latch_mask_dispatcher_defines.svh"

module ilmd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cmd_valid,
    input logic                        cmd_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [ilmd_pkg::KIND_W-1:0] rsp_kind,
    input logic [ilmd_pkg::EV_W-1:0]   rsp_event,
    input logic                        rsp_sense,
    input logic                        rsp_last
);

    // A stalled result item must hold its valid, kind, event number and last flag.
    `ILMD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_event) && $stable(rsp_last), "stalled result changed")

    // Only dispatched items carry an event number.
    `ILMD_ASSERT_IMPLY(a_event_zero, rsp_valid && (rsp_kind != ilmd_pkg::KIND_DISPATCH), rsp_event == '0, "event number on a non-dispatch result")

    // Only sense items carry a sense bit.
    `ILMD_ASSERT_IMPLY(a_sense_zero, rsp_valid && (rsp_kind != ilmd_pkg::KIND_SENSE), !rsp_sense, "sense bit on a non-sense result")

    // The block is busy in the cycle after it takes an item.
    `ILMD_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "ready stayed high after an accepted item")

endmodule

bind interrupt_latch_mask_dispatcher ilmd_checker u_ilmd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_kind  (rsp.kind),
    .rsp_event (rsp.dispatched_event),
    .rsp_sense (rsp.sense_bit),
    .rsp_last  (rsp.last)
);
